// ===== hw/rtl/mbrp_pkg.sv =====
// Shared constants, types and character helpers for the Modbus ASCII read-reply parser.
package mbrp_pkg;

   // Line store geometry.
   localparam int LINE_CAPACITY = 24;
   localparam int KEPT_CHARS    = 13;
   localparam int MIN_FRAME     = 13;

   // Protocol constants.
   localparam logic [7:0] FUNC_READ  = 8'h03;
   localparam logic [7:0] BYTE_COUNT = 8'h02;
   localparam logic [7:0] START_MARK = 8'h3A;
   localparam logic [7:0] LINE_FEED  = 8'h0A;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // Result status codes carried on rsp_tuser.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REJECT  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_EXPECTED_SLAVE = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS  = 1'b1;

   // Configuration register reset values.
   localparam logic [7:0]  EXPECTED_SLAVE_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd100;

   // Held characters of one line, character 0 in the lowest entry.
   typedef logic [KEPT_CHARS-1:0][7:0] line_type;

   // One result: status and register value.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] reg_value;
   } result_type;

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b1, 4'(c - 8'h57)};
      end
      return d;
   endfunction

   // A hex pair read left to right; a non-hex character ends the pair.
   function automatic logic [7:0] pair_value(input logic [7:0] hi_c, input logic [7:0] lo_c);
      logic [4:0] hi;
      logic [4:0] lo;
      logic [7:0] v;
      hi = hex_digit(hi_c);
      lo = hex_digit(lo_c);
      if (!hi[4]) begin
         v = 8'd0;
      end else if (!lo[4]) begin
         v = {4'd0, hi[3:0]};
      end else begin
         v = {hi[3:0], lo[3:0]};
      end
      return v;
   endfunction

endpackage

// ===== hw/rtl/mbrp_frame_check.sv =====
// Frame check: decodes the six hex pairs of a finished line and judges the reply.
module mbrp_frame_check (
   input  mbrp_pkg::line_type   line,
   input  logic                 count_ok,
   input  logic [7:0]           expected_slave,
   output mbrp_pkg::result_type result
);

   logic [7:0] slave;
   logic [7:0] func;
   logic [7:0] count;
   logic [7:0] data_hi;
   logic [7:0] data_lo;
   logic [7:0] lrc;
   logic [7:0] sum;
   logic       header_ok;
   logic       fields_ok;
   logic       lrc_ok;

   // Decode the pairs at their fixed offsets after the colon.
   assign slave   = mbrp_pkg::pair_value(line[1],  line[2]);
   assign func    = mbrp_pkg::pair_value(line[3],  line[4]);
   assign count   = mbrp_pkg::pair_value(line[5],  line[6]);
   assign data_hi = mbrp_pkg::pair_value(line[7],  line[8]);
   assign data_lo = mbrp_pkg::pair_value(line[9],  line[10]);
   assign lrc     = mbrp_pkg::pair_value(line[11], line[12]);

   // The LRC is the two's complement of the byte sum of the other fields.
   assign sum    = slave + func + count + data_hi + data_lo;
   assign lrc_ok = (8'd0 - sum) == lrc;

   assign header_ok = count_ok && (line[0] == mbrp_pkg::START_MARK);
   assign fields_ok = (slave == expected_slave) && (func == mbrp_pkg::FUNC_READ)
                      && (count == mbrp_pkg::BYTE_COUNT);

   // Any failed check rejects the frame with a zero value.
   always_comb begin
      if (header_ok && fields_ok && lrc_ok) begin
         result.status    = mbrp_pkg::ST_OK;
         result.reg_value = {data_hi, data_lo};
      end else begin
         result.status    = mbrp_pkg::ST_REJECT;
         result.reg_value = 16'd0;
      end
   end

endmodule

// ===== hw/rtl/modbus_ascii_read_reply_parser_top.sv =====
// Top level of the Modbus ASCII read-reply parser: request, wait state and result registers.
// The parser takes one request per clock cycle while requests are not held back, and answers
// a line feed or the final timeout tick with one result: the request is captured in an input
// register when accepted, and the line check, the wait state update and the result are then
// settled into the result register, which drives the result port. Requests are held back only
// while a result sits in the result register and rsp_tready is low. Configuration writes are
// always ready and should be made only while no reply is being waited for.
module modbus_ascii_read_reply_parser_top #(
   parameter int LineCapacity = mbrp_pkg::LINE_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] action
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] reg_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CntW = $clog2(LineCapacity);

   // Configuration registers.
   logic [7:0]  expected_slave_ff;
   logic [15:0] timeout_ticks_ff;

   // Input register.
   logic        in_valid_ff;
   logic [1:0]  in_action_ff;
   logic [7:0]  in_byte_ff;

   // Wait state.
   logic            waiting_ff, waiting_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [15:0]     ticks_ff, ticks_in;
   mbrp_pkg::line_type line_ff;
   mbrp_pkg::line_type line_view;
   logic [mbrp_pkg::KEPT_CHARS-1:0] line_we;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   mbrp_pkg::result_type rsp_data_ff, rsp_data_in;

   logic                 advance;
   logic                 work;
   logic                 byte_room;
   logic [CntW-1:0]      count_step;
   logic                 count_ok;
   mbrp_pkg::result_type frame_result;

   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_slave_ff <= mbrp_pkg::EXPECTED_SLAVE_RESET;
         timeout_ticks_ff  <= mbrp_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mbrp_pkg::CSR_EXPECTED_SLAVE: expected_slave_ff <= csr_wdata[7:0];
            mbrp_pkg::CSR_TIMEOUT_TICKS:  timeout_ticks_ff  <= csr_wdata;
            default:                      expected_slave_ff <= expected_slave_ff;
         endcase
      end
   end

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign work       = in_valid_ff && advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
   end

   // The current character lands at the count while there is room; the check sees it too.
   assign byte_room = count_ff < CntW'(LineCapacity - 1);

   // Character count after the registered byte, with the line-full limit applied.
   assign count_step = byte_room ? count_ff + CntW'(1) : count_ff;
   assign count_ok   = count_step >= CntW'(mbrp_pkg::MIN_FRAME);

   always_comb begin
      for (int i = 0; i < mbrp_pkg::KEPT_CHARS; i++) begin
         line_we[i]   = waiting_ff && (in_action_ff == mbrp_pkg::ACT_BYTE) && byte_room
                        && (count_ff == CntW'(i));
         line_view[i] = line_we[i] ? in_byte_ff : line_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < mbrp_pkg::KEPT_CHARS; i++) begin
         if (work && line_we[i]) begin
            line_ff[i] <= in_byte_ff;
         end
      end
   end

   mbrp_frame_check u_frame_check (
      .line           (line_view),
      .count_ok       (count_ok),
      .expected_slave (expected_slave_ff),
      .result         (frame_result)
   );

   // Wait state update and result selection for the registered request.
   always_comb begin
      waiting_in            = waiting_ff;
      count_in              = count_ff;
      ticks_in              = ticks_ff;
      rsp_valid_in          = 1'b0;
      rsp_data_in           = frame_result;
      unique case (in_action_ff)
         mbrp_pkg::ACT_START: begin
            waiting_in = 1'b1;
            count_in   = '0;
            ticks_in   = timeout_ticks_ff;
         end
         mbrp_pkg::ACT_BYTE: begin
            if (waiting_ff) begin
               count_in = count_step;
               if (in_byte_ff == mbrp_pkg::LINE_FEED) begin
                  waiting_in   = 1'b0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         mbrp_pkg::ACT_TICK: begin
            if (waiting_ff) begin
               if (ticks_ff <= 16'd1) begin
                  ticks_in              = 16'd0;
                  waiting_in            = 1'b0;
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.status    = mbrp_pkg::ST_TIMEOUT;
                  rsp_data_in.reg_value = 16'd0;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end
         default: begin
            waiting_in = waiting_ff;
         end
      endcase
   end

   // Wait state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         count_ff   <= '0;
         ticks_ff   <= 16'd0;
      end else if (work) begin
         waiting_ff <= waiting_in;
         count_ff   <= count_in;
         ticks_ff   <= ticks_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= work && rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work && rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.reg_value;
   assign rsp_tuser  = rsp_data_ff.status;

endmodule

// ===== hw/rtl/mbrp_checker.sv =====
// Port checker for the Modbus ASCII read-reply parser, bound to its top level.
module mbrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only a valid reply carries a nonzero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != mbrp_pkg::ST_OK |-> rsp_tdata == 16'd0)
      else $error("rejected or timed-out result carries a value");

   // A new result follows an accepted request that has passed the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching request");

   // With the result register empty, requests are never held back.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with no result pending");

endmodule

bind modbus_ascii_read_reply_parser_top mbrp_checker u_mbrp_checker (.*);

// ===== tb/modbus_ascii_read_reply_parser_top_tb.sv =====
// Self-checking testbench for the Modbus ASCII read-reply parser top level.
module modbus_ascii_read_reply_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbrp_pkg::*;

   // Action code that the block must ignore.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
   localparam int LIVE_PER_PHASE = 275;
   localparam int PHASES = 6;

   // Reply predictor: keeps its own copy of the wait state and the registers.
   class reply_scoreboard;
      logic [7:0]  want_slave;
      logic [15:0] tick_limit;
      bit          armed;
      int unsigned chars_seen;
      logic [7:0]  held_chars [KEPT_CHARS];
      logic [15:0] ticks_left;
      result_type  pending [$];
      int unsigned failures;

      function new();
         want_slave = EXPECTED_SLAVE_RESET;
         tick_limit = TIMEOUT_TICKS_RESET;
         armed      = 1'b0;
         chars_seen = 0;
         ticks_left = '0;
         failures   = 0;
         foreach (held_chars[k]) held_chars[k] = 8'd0;
      endfunction

      function void write_reg(input logic idx, input logic [15:0] v);
         if (idx == CSR_EXPECTED_SLAVE) begin
            want_slave = v[7:0];
         end else begin
            tick_limit = v;
         end
      endfunction

      // Value of one hex character, or -1 when the character is not a digit.
      function int hex_value(input logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
         return -1;
      endfunction

      // A digit pair stops at the first character that is not a digit.
      function logic [7:0] pair_at(input int pos);
         int hi;
         int lo;
         hi = hex_value(held_chars[pos]);
         if (hi < 0) return 8'd0;
         lo = hex_value(held_chars[pos+1]);
         if (lo < 0) return 8'(hi);
         return 8'(hi * 16 + lo);
      endfunction

      // Judge the finished line: framing, header fields and checksum.
      function result_type judge_line();
         result_type r;
         logic [7:0] f [6];
         logic [7:0] total;
         r = '{status: ST_REJECT, reg_value: 16'd0};
         if (chars_seen < MIN_FRAME || held_chars[0] != START_MARK) return r;
         for (int k = 0; k < 6; k++) f[k] = pair_at(1 + 2 * k);
         if (f[0] != want_slave || f[1] != FUNC_READ || f[2] != BYTE_COUNT) return r;
         total = f[0] + f[1] + f[2] + f[3] + f[4];
         if (8'(-total) != f[5]) return r;
         r = '{status: ST_OK, reg_value: {f[3], f[4]}};
         return r;
      endfunction

      // Apply one accepted request; returns 1 when the block does not ignore it.
      function bit note_request(input logic [1:0] act, input logic [7:0] c);
         if (act == ACT_START) begin
            foreach (held_chars[k]) held_chars[k] = 8'd0;
            chars_seen = 0;
            ticks_left = tick_limit;
            armed      = 1'b1;
            return 1'b1;
         end
         if (!armed) return 1'b0;
         if (act == ACT_BYTE) begin
            if (chars_seen < LINE_CAPACITY - 1) begin
               if (chars_seen < KEPT_CHARS) held_chars[chars_seen] = c;
               chars_seen++;
            end
            if (c == LINE_FEED) begin
               armed = 1'b0;
               pending.push_back(judge_line());
            end
            return 1'b1;
         end
         if (act == ACT_TICK) begin
            if (ticks_left <= 16'd1) begin
               ticks_left = '0;
               armed      = 1'b0;
               pending.push_back('{status: ST_TIMEOUT, reg_value: 16'd0});
            end else begin
               ticks_left--;
            end
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // Compare one result with the oldest expectation.
      function void check_result(input logic [1:0] st, input logic [15:0] v);
         result_type want;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected, actual status %0d value %h", $realtime,
                     st, v);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (st !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
                     want.status, st);
            failures++;
         end
         if (v !== want.reg_value) begin
            $display("%0t: reg_value mismatch, expected %h, actual %h", $realtime,
                     want.reg_value, v);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [1:0]  req_tuser = ACT_START;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_EXPECTED_SLAVE;
   logic [15:0] csr_wdata = 16'd0;

   reply_scoreboard sb;
   int burst_left = 0;
   int live_items = 0;
   int stall_mode = 0;
   int hold_left = 0;

   modbus_ascii_read_reply_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Result side: check each accepted result, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata);
      end
      if (hold_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         hold_left  = $urandom_range(1, 60);
      end
      hold_left--;
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= (hold_left % 16 == 0);
         end
      endcase
   end

   // Send one request and wait for it to be taken; bursts end in a random gap that may be empty.
   task automatic send_request(input logic [1:0] act, input logic [7:0] c);
      int pause;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= c;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      if (sb.note_request(act, c)) live_items++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
         pause = ($urandom_range(0, 3) == 0) ? 0
               : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 6);
         if (pause > 0) begin
            req_tvalid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
      end
   endtask

   // Hex digit for a nibble, letters in random case.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] letter_a;
      letter_a = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41;
      if (n < 4'd10) return 8'h30 + 8'(n);
      return letter_a + 8'(n) - 8'd10;
   endfunction

   // Random character that is neither a hex digit nor a line feed.
   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      c = 8'($urandom);
      while (sb.hex_value(c) >= 0 || c == LINE_FEED) c = 8'($urandom);
      return c;
   endfunction

   function automatic logic [7:0] random_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // A reply frame with random content, mostly well formed, sometimes damaged.
   task automatic run_frame();
      logic [7:0] fld [6];
      logic [7:0] text [$];
      logic [7:0] total;
      int cut;
      fld[0] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : sb.want_slave;
      fld[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_READ;
      fld[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : BYTE_COUNT;
      fld[3] = random_data();
      fld[4] = random_data();
      total  = fld[0] + fld[1] + fld[2] + fld[3] + fld[4];
      fld[5] = 8'(-total);
      if ($urandom_range(0, 9) == 0) fld[5] = fld[5] ^ 8'($urandom_range(1, 255));
      text.push_back(START_MARK);
      for (int k = 0; k < 6; k++) begin
         text.push_back(hex_char(fld[k][7:4]));
         text.push_back(hex_char(fld[k][3:0]));
      end
      case ($urandom_range(0, 11))
         0: begin
            // Missing start mark.
            text[0] = random_non_hex();
         end
         1: begin
            // A stray character cuts one digit pair short.
            text[$urandom_range(1, 12)] = random_non_hex();
         end
         2: begin
            // Trailing junk, sometimes running past the line capacity.
            repeat ($urandom_range(1, 20)) text.push_back(random_non_hex());
         end
         3: begin
            // Frame too short.
            cut = $urandom_range(0, 12);
            while (text.size() > cut) void'(text.pop_back());
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) != 0) text.push_back(CARRIAGE_RETURN);
      text.push_back(LINE_FEED);
      // Now and then an aborted wait comes first, so the start restarts it.
      if ($urandom_range(0, 9) == 0) begin
         send_request(ACT_START, 8'($urandom));
         repeat ($urandom_range(1, 5)) send_request(ACT_BYTE, random_non_hex());
      end
      send_request(ACT_START, 8'($urandom));
      foreach (text[k]) begin
         if ($urandom_range(0, 19) == 0) send_request(ACT_TICK, 8'($urandom));
         send_request(ACT_BYTE, text[k]);
      end
   endtask

   // A wait that ends in timeout, with stray characters mixed in; a long timeout is closed by a line feed instead.
   task automatic run_timeout();
      send_request(ACT_START, 8'($urandom));
      if (sb.ticks_left > 16'd300) begin
         repeat (3) send_request(ACT_TICK, 8'($urandom));
         send_request(ACT_BYTE, LINE_FEED);
         return;
      end
      while (sb.armed) begin
         if ($urandom_range(0, 7) == 0) begin
            send_request(ACT_BYTE, random_non_hex());
         end else begin
            send_request(ACT_TICK, 8'($urandom));
         end
      end
   endtask

   task automatic run_noise();
      repeat ($urandom_range(3, 15)) send_request(2'($urandom), 8'($urandom));
   endtask

   task automatic run_directed();
      string reply;
      reply = ":010302ffffFC\r\n";
      // Valid reply with the largest register value in lower-case digits.
      send_request(ACT_START, 8'h00);
      for (int k = 0; k < reply.len(); k++) send_request(ACT_BYTE, reply[k]);
      // Unused code, tick and line feed while idle are all ignored.
      send_request(ACT_UNUSED, 8'hFF);
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_BYTE, LINE_FEED);
      // Restart during a wait, then a frame far too short.
      send_request(ACT_START, 8'hFF);
      send_request(ACT_START, 8'h5A);
      send_request(ACT_BYTE, START_MARK);
      send_request(ACT_BYTE, LINE_FEED);
   endtask

   // Close any open wait, let the block drain and go quiet.
   task automatic settle();
      if (sb.armed) send_request(ACT_BYTE, LINE_FEED);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write both registers, holding the write valid across the two requests.
   task automatic write_config(input logic [7:0] slave, input logic [15:0] ticks);
      csr_valid <= 1'b1;
      csr_index <= CSR_EXPECTED_SLAVE;
      csr_wdata <= {8'($urandom), slave};
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_reg(CSR_EXPECTED_SLAVE, {8'd0, slave});
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= ticks;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_reg(CSR_TIMEOUT_TICKS, ticks);
      csr_valid <= 1'b0;
   endtask

   // Main sequence: reset, directed frames, then random phases under new settings.
   initial begin
      int pick;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            settle();
            case (ph)
               1: write_config(8'h00, 16'd1);
               2: write_config(8'hFF, 16'hFFFF);
               3: write_config(8'($urandom), 16'd0);
               4: write_config(8'($urandom), 16'($urandom_range(2, 40)));
               default: write_config(8'($urandom), 16'($urandom_range(8, 250)));
            endcase
         end
         while (live_items < (ph + 1) * LIVE_PER_PHASE) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
               run_frame();
            end else if (pick < 17) begin
               run_timeout();
            end else begin
               run_noise();
            end
         end
      end
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mbrp_pkg.sv
hw/rtl/mbrp_frame_check.sv
hw/rtl/modbus_ascii_read_reply_parser_top.sv
hw/rtl/mbrp_checker.sv
tb/modbus_ascii_read_reply_parser_top_tb.sv
